/* src/mcw_pkg.sv */
// package for the minimum covering window block
// shared types, codes and size constants; no dependencies
package mcw_pkg;

  localparam int TEXT_MAX    = 4096;
  localparam int PAT_MAX     = 64;
  localparam int TEXT_AW     = $clog2(TEXT_MAX);
  localparam int IDX_W       = $clog2(TEXT_MAX + 1);
  localparam int NEED_W      = $clog2(PAT_MAX + 1);
  localparam int HAVE_W      = $clog2(TEXT_MAX + 1);
  localparam int CNT_W       = NEED_W + HAVE_W;
  localparam int SYM_W       = 8;
  localparam int SYM_N       = 256;
  localparam int DIST_W      = 9;
  localparam int START_W     = 12;
  localparam int LEN_W       = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_PAT  = 2'd0;
  localparam logic [1:0] FUNC_TEXT = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  typedef enum logic [1:0] {
    OP_PAT,
    OP_TEXT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_UPD,
    ST_TXT_UPD,
    ST_CHECK,
    ST_LREAD,
    ST_LUPD
  } state_t;

endpackage

/* src/mcw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mcw_front.sv */
// front end: takes input transfers, decodes func into a command, drops unused codes
// depends on mcw_pkg
module mcw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic [1:0]              in_tuser,
  output logic                    push,
  output mcw_pkg::cmd_t           push_cmd,
  input  logic                    q_full
);
  import mcw_pkg::*;

  logic fv_r, fv_nxt;
  cmd_t cmd_r, cmd_nxt;
  cmd_t dec;
  logic keep;

  always_comb begin
    dec.sym = in_tdata[SYM_W-1:0];
    dec.op  = OP_PAT;
    keep    = 1'b1;
    case (in_tuser)
      FUNC_PAT:  dec.op = OP_PAT;
      FUNC_TEXT: dec.op = OP_TEXT;
      FUNC_END:  dec.op = OP_END;
      default:   keep = 1'b0;
    endcase
  end

  assign in_tready = !fv_r || !q_full;
  assign push      = fv_r && !q_full;
  assign push_cmd  = cmd_r;

  always_comb begin
    fv_nxt  = fv_r;
    cmd_nxt = cmd_r;
    if (push) begin
      fv_nxt = 1'b0;
    end
    if (in_tvalid && in_tready && keep) begin
      fv_nxt  = 1'b1;
      cmd_nxt = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

/* src/mcw_queue.sv */
// short command queue between front end and back end
// depends on mcw_pkg
module mcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mcw_pkg::cmd_t head_cmd,
  output logic          not_empty
);
  import mcw_pkg::*;

  cmd_t            q_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (Q_AW+1)'(QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_cmd  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/mcw_back.sv */
// back end: count tables, text buffer, window sequencer and result register
// depends on mcw_pkg and mcw_ram
module mcw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         not_empty,
  input  mcw_pkg::cmd_t                head_cmd,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic                         out_found,
  output logic [mcw_pkg::START_W-1:0]  out_start,
  output logic [mcw_pkg::LEN_W-1:0]    out_len,
  output logic                         out_ovf
);
  import mcw_pkg::*;

  state_t              state_r, state_nxt;
  logic [DIST_W-1:0]   needed_r, needed_nxt;
  logic [DIST_W-1:0]   met_r, met_nxt;
  logic [IDX_W-1:0]    left_r, left_nxt;
  logic [IDX_W-1:0]    right_r, right_nxt;
  logic [IDX_W-1:0]    best_len_r, best_len_nxt;
  logic [TEXT_AW-1:0]  best_start_r, best_start_nxt;
  logic [NEED_W-1:0]   pat_used_r, pat_used_nxt;
  logic                dropped_r, dropped_nxt;
  logic [SYM_N-1:0]    vld_r, vld_nxt;
  logic                vq_r;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [SYM_W-1:0]    lc_r, lc_nxt;
  logic                ov_r, ov_nxt;
  logic                of_r, of_nxt;
  logic [START_W-1:0]  os_r, os_nxt;
  logic [LEN_W-1:0]    ol_r, ol_nxt;
  logic                oo_r, oo_nxt;

  logic                cnt_we;
  logic [SYM_W-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                txt_we;
  logic [SYM_W-1:0]    txt_rdata;
  logic [NEED_W-1:0]   need_rd;
  logic [HAVE_W-1:0]   have_rd, have_inc, have_dec;
  logic [IDX_W-1:0]    cur_len;
  logic                out_free, ok;

  mcw_ram #(.WIDTH(CNT_W), .DEPTH(SYM_N)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mcw_ram #(.WIDTH(SYM_W), .DEPTH(TEXT_MAX)) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (right_r[TEXT_AW-1:0]),
    .wdata (head_cmd.sym),
    .raddr (left_r[TEXT_AW-1:0]),
    .rdata (txt_rdata)
  );

  assign need_rd  = vq_r ? cnt_rdata[CNT_W-1:HAVE_W] : '0;
  assign have_rd  = vq_r ? cnt_rdata[HAVE_W-1:0] : '0;
  assign have_inc = have_rd + 1'b1;
  assign have_dec = (have_rd != '0) ? have_rd - 1'b1 : have_rd;
  assign cur_len  = right_r - left_r;
  assign out_free = !ov_r || out_tready;
  assign ok       = (best_len_r != '0) && (right_r >= IDX_W'(pat_used_r));
  assign cnt_raddr = (state_r == ST_LREAD) ? txt_rdata : head_cmd.sym;

  always_comb begin
    state_nxt      = state_r;
    needed_nxt     = needed_r;
    met_nxt        = met_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    pat_used_nxt   = pat_used_r;
    dropped_nxt    = dropped_r;
    vld_nxt        = vld_r;
    sym_nxt        = sym_r;
    lc_nxt         = lc_r;
    ov_nxt         = ov_r && !out_tready;
    of_nxt         = of_r;
    os_nxt         = os_r;
    ol_nxt         = ol_r;
    oo_nxt         = oo_r;
    pop            = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = sym_r;
    cnt_wdata      = '0;
    txt_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (not_empty) begin
          sym_nxt = head_cmd.sym;
          case (head_cmd.op)
            OP_PAT: begin
              pop = 1'b1;
              if (right_r == '0) begin
                if (pat_used_r >= NEED_W'(PAT_MAX)) begin
                  dropped_nxt = 1'b1;
                end else begin
                  state_nxt = ST_PAT_UPD;
                end
              end
            end
            OP_TEXT: begin
              pop = 1'b1;
              if (right_r >= IDX_W'(TEXT_MAX)) begin
                dropped_nxt = 1'b1;
              end else begin
                txt_we    = 1'b1;
                state_nxt = ST_TXT_UPD;
              end
            end
            OP_END: begin
              if (out_free) begin
                pop            = 1'b1;
                ov_nxt         = 1'b1;
                of_nxt         = ok;
                os_nxt         = ok ? START_W'(best_start_r) : '0;
                ol_nxt         = ok ? LEN_W'(best_len_r) : '0;
                oo_nxt         = dropped_r;
                needed_nxt     = '0;
                met_nxt        = '0;
                left_nxt       = '0;
                right_nxt      = '0;
                best_len_nxt   = '0;
                best_start_nxt = '0;
                pat_used_nxt   = '0;
                dropped_nxt    = 1'b0;
                vld_nxt        = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_PAT_UPD: begin
        cnt_we           = 1'b1;
        cnt_wdata        = {need_rd + 1'b1, have_rd};
        vld_nxt[sym_r]   = 1'b1;
        pat_used_nxt     = pat_used_r + 1'b1;
        if (need_rd == '0) begin
          needed_nxt = needed_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_TXT_UPD: begin
        cnt_we         = 1'b1;
        cnt_wdata      = {need_rd, have_inc};
        vld_nxt[sym_r] = 1'b1;
        if (need_rd != '0 && have_inc == HAVE_W'(need_rd)) begin
          met_nxt = met_r + 1'b1;
        end
        right_nxt = right_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (left_r < right_r && met_r == needed_r) begin
          if (best_len_r == '0 || cur_len < best_len_r) begin
            best_len_nxt   = cur_len;
            best_start_nxt = left_r[TEXT_AW-1:0];
          end
          state_nxt = ST_LREAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LREAD: begin
        lc_nxt    = txt_rdata;
        state_nxt = ST_LUPD;
      end
      ST_LUPD: begin
        cnt_we        = 1'b1;
        cnt_waddr     = lc_r;
        cnt_wdata     = {need_rd, have_dec};
        vld_nxt[lc_r] = 1'b1;
        if (need_rd != '0 && have_dec < HAVE_W'(need_rd)) begin
          met_nxt = met_r - 1'b1;
        end
        left_nxt  = left_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      needed_r     <= '0;
      met_r        <= '0;
      left_r       <= '0;
      right_r      <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      pat_used_r   <= '0;
      dropped_r    <= 1'b0;
      vld_r        <= '0;
      vq_r         <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      needed_r     <= needed_nxt;
      met_r        <= met_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      pat_used_r   <= pat_used_nxt;
      dropped_r    <= dropped_nxt;
      vld_r        <= vld_nxt;
      vq_r         <= vld_r[cnt_raddr];
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    lc_r  <= lc_nxt;
    of_r  <= of_nxt;
    os_r  <= os_nxt;
    ol_r  <= ol_nxt;
    oo_r  <= oo_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_found  = of_r;
  assign out_start  = os_r;
  assign out_len    = ol_r;
  assign out_ovf    = oo_r;

  a_met_bound: assert property (@(posedge clk) disable iff (!rst_n)
    met_r <= needed_r) else $error("met count above needed count");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= right_r) else $error("left index passed right index");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_len_r <= right_r) else $error("best length longer than text");

  a_shrink_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LREAD |=> state_r == ST_LUPD && left_r < right_r)
    else $error("shrink step on empty window");

endmodule

/* src/minimum_covering_window.sv */
// top level of the minimum covering window block
// depends on mcw_pkg, mcw_front, mcw_queue, mcw_back, mcw_ram
//
//  channel  dir  tdata                        tuser
//  in_      in   [7:0] symbol                 [1:0] func
//  out_     out  [11:0] start, [24:12] length [0] found, [1] overflow
//
// stored pattern byte: ST_IDLE, then ST_PAT_UPD; end item: ST_IDLE once out_free
// stored text byte: ST_IDLE, ST_TXT_UPD, ST_CHECK, then ST_LREAD and ST_LUPD per character dropped
//   from the left of the window, set by the read-modify-write of the count ram and the registered text ram read
// rst_n clears the count tables at once through per-byte valid bits
// a 4-entry queue lets the front keep taking transfers while the back end works
// or a result waits on out_tready
module minimum_covering_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] window_start, [24:12] window_length
  output logic [1:0]  out_tuser   // [0] found, [1] overflow
);
  import mcw_pkg::*;

  logic               push, q_full, pop, not_empty;
  cmd_t               push_cmd, head_cmd;
  logic               found, ovf;
  logic [START_W-1:0] start;
  logic [LEN_W-1:0]   len;

  mcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  mcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty)
  );

  mcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_found  (found),
    .out_start  (start),
    .out_len    (len),
    .out_ovf    (ovf)
  );

  assign out_tdata = {(32 - START_W - LEN_W)'(0), len, start};
  assign out_tuser = {ovf, found};

endmodule
